// ===== hdl/tcw_pkg.sv =====
// ============================================================================
// Text console writer package
// Shared constants, command and register codes, and the put-step flags.
// ============================================================================
package tcw_pkg;

    // Built screen size defaults.
    localparam int MAX_COLS_DEFAULT = 128;
    localparam int MAX_ROWS_DEFAULT = 32;

    // Field widths of the channels.
    localparam int CELL_W       = 16;
    localparam int CHAR_W       = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int CURSOR_COL_W = 8;
    localparam int CURSOR_ROW_W = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WIDTH_REG_W  = 8;
    localparam int HEIGHT_REG_W = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_WORD   = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 8'd80;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 6'd25;
    localparam logic [CELL_W-1:0]       COLOUR_RESET = 16'h0700;

    // Commands.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Decisions made for one put command.
    typedef struct packed {
        logic scroll;
        logic write_en;
    } put_plan_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tcw_cursor.sv =====
// ============================================================================
// Text console cursor step
// Works out where a put lands, whether it scrolls, and the cursor afterwards.
// ============================================================================
module tcw_cursor #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEFAULT,
    localparam int COL_W  = $clog2(MAX_COLS + 1),
    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CNT_W  = $clog2(MAX_ROWS + 1)
) (
    input  logic [COL_W-1:0]   cur_col,
    input  logic [ROW_W-1:0]   cur_row,
    input  logic [COL_W-1:0]   width_used,
    input  logic [CNT_W-1:0]   height_used,
    input  logic               is_newline,
    output tcw_pkg::put_plan_t plan,
    output logic [ROW_W-1:0]   cell_row,
    output logic [CIDX_W-1:0]  cell_col,
    output logic [COL_W-1:0]   next_col,
    output logic [ROW_W-1:0]   next_row
);

    logic [ROW_W-1:0] row_sat;
    logic [CNT_W-1:0] row_inc;
    logic             wrap;
    logic [COL_W-1:0] col_after;

    always_comb
    begin
        // A cursor left below the rows in use (height lowered) sits on the last row.
        if (CNT_W'(cur_row) >= height_used)
        begin
            row_sat = ROW_W'(height_used - CNT_W'(1));
        end
        else
        begin
            row_sat = cur_row;
        end

        wrap    = (cur_col >= width_used) || is_newline;
        row_inc = CNT_W'(row_sat) + CNT_W'(1);

        plan.write_en = !is_newline;
        plan.scroll   = wrap && (row_inc >= height_used);

        if (plan.scroll)
        begin
            cell_row = ROW_W'(height_used - CNT_W'(1));
        end
        else if (wrap)
        begin
            cell_row = ROW_W'(row_inc);
        end
        else
        begin
            cell_row = row_sat;
        end

        col_after = wrap ? '0 : cur_col;
        cell_col  = CIDX_W'(col_after);
        next_row  = cell_row;
        next_col  = is_newline ? col_after : col_after + COL_W'(1);
    end

endmodule

// ===== hdl/text_console_writer_core.sv =====
// ============================================================================
// Text console writer core
// Character-cell console: a screen store in RAM, a cursor, puts and reads.
// ============================================================================
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid / in_ready     command, char_code, read_row, read_col
//  out      output     out_valid / out_ready   cell_value, cursor_col, cursor_row, scrolled
//  cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A put that does not scroll writes its cell as the transaction is taken.
// A read passes through S_READ, as the screen RAM registers its read data.
// A scrolling put copies each row up and then blanks the last row (only
// blanks it when one row is in use), one cell a cycle through the single
// write port of the screen RAM. After reset a clearing pass writes zero to
// all MAX_ROWS * MAX_COLS cells, one a cycle, before in_ready rises.
// A stalled result waits in the output register; the next command is taken
// meanwhile unless a further result would have nowhere to go.
//
module text_console_writer_core #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tcw_pkg::READ_ROW_W-1:0]      read_row,
    input  logic [tcw_pkg::READ_COL_W-1:0]      read_col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tcw_pkg::CELL_W-1:0]          cell_value,
    output logic [tcw_pkg::CURSOR_COL_W-1:0]    cursor_col,
    output logic [tcw_pkg::CURSOR_ROW_W-1:0]    cursor_row,
    output logic                                scrolled,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CELL_W = tcw_pkg::CELL_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_PUT,
        S_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [CIDX_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    state_t                           state_reg, state_next;
    logic [ADDR_W-1:0]                clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0]                 cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]                 cur_row_reg, cur_row_next;
    logic [tcw_pkg::WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [tcw_pkg::HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [CELL_W-1:0]                colour_reg, colour_next;
    logic [ROW_W-1:0]                 scr_row_reg, scr_row_next;
    logic [CIDX_W-1:0]                scr_col_reg, scr_col_next;
    logic                             pend_reg, pend_next;
    logic [ADDR_W-1:0]                pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]                put_addr_reg, put_addr_next;
    logic [CELL_W-1:0]                put_data_reg, put_data_next;
    logic                             put_we_reg, put_we_next;
    logic                             rd_zero_reg, rd_zero_next;
    logic [CELL_W-1:0]                hold_cell_reg, hold_cell_next;
    logic                             hold_scr_reg, hold_scr_next;
    logic                             out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]                cell_value_reg, cell_value_next;
    logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic                             scrolled_reg, scrolled_next;

    logic [COL_W-1:0]   w_used;
    logic [CNT_W-1:0]   h_used;
    tcw_pkg::put_plan_t plan;
    logic [ROW_W-1:0]   plan_row;
    logic [CIDX_W-1:0]  plan_col;
    logic [COL_W-1:0]   plan_next_col;
    logic [ROW_W-1:0]   plan_next_row;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    logic               in_take;
    logic               out_free;
    logic               fin;
    logic [CELL_W-1:0]  fin_cell;
    logic               fin_scr;
    logic [CELL_W-1:0]  put_word;
    logic               last_col;

    // Width and height in use, a zero taken as one, clamped to the built screen.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_used = COL_W'(1);
        end
        else if (int'(width_reg) > MAX_COLS)
        begin
            w_used = COL_W'(MAX_COLS);
        end
        else
        begin
            w_used = COL_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_used = CNT_W'(1);
        end
        else if (int'(height_reg) > MAX_ROWS)
        begin
            h_used = CNT_W'(MAX_ROWS);
        end
        else
        begin
            h_used = CNT_W'(height_reg);
        end
    end

    tcw_cursor #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cursor (
        .cur_col     (cur_col_reg),
        .cur_row     (cur_row_reg),
        .width_used  (w_used),
        .height_used (h_used),
        .is_newline  (char_code == tcw_pkg::NEWLINE_CODE),
        .plan        (plan),
        .cell_row    (plan_row),
        .cell_col    (plan_col),
        .next_col    (plan_next_col),
        .next_row    (plan_next_row)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign put_word  = {{(CELL_W - tcw_pkg::CHAR_W){1'b0}}, char_code} | colour_reg;
    assign last_col  = (COL_W'(scr_col_reg) == w_used - COL_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        colour_next     = colour_reg;
        scr_row_next    = scr_row_reg;
        scr_col_next    = scr_col_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        put_addr_next   = put_addr_reg;
        put_data_next   = put_data_reg;
        put_we_next     = put_we_reg;
        rd_zero_next    = rd_zero_reg;
        hold_cell_next  = hold_cell_reg;
        hold_scr_next   = hold_scr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cell_value_next = cell_value_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        scrolled_next   = scrolled_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = cell_addr(ROW_W'(scr_row_reg + ROW_W'(1)), scr_col_reg);

        fin      = 1'b0;
        fin_cell = '0;
        fin_scr  = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_SCREEN_WIDTH:  width_next  = cfg_data[tcw_pkg::WIDTH_REG_W-1:0];
                tcw_pkg::CFG_SCREEN_HEIGHT: height_next = cfg_data[tcw_pkg::HEIGHT_REG_W-1:0];
                tcw_pkg::CFG_COLOUR_WORD:   colour_next = cfg_data;
                default:                    ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_take && (command == tcw_pkg::CMD_READ))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cell_addr(ROW_W'(read_row), CIDX_W'(read_col));
                    rd_zero_next = (int'(read_row) >= MAX_ROWS) || (int'(read_col) >= MAX_COLS);
                    state_next   = S_READ;
                end
                else if (in_take)
                begin
                    cur_col_next = plan_next_col;
                    cur_row_next = plan_next_row;
                    if (plan.scroll)
                    begin
                        put_addr_next  = cell_addr(plan_row, plan_col);
                        put_data_next  = put_word;
                        put_we_next    = plan.write_en;
                        scr_row_next   = '0;
                        scr_col_next   = '0;
                        pend_next      = 1'b0;
                        state_next     = (h_used > CNT_W'(1)) ? S_COPY : S_FILL;
                    end
                    else
                    begin
                        ram_we    = plan.write_en;
                        ram_waddr = cell_addr(plan_row, plan_col);
                        ram_wdata = put_word;
                        fin       = 1'b1;
                    end
                end
            end

            S_READ:
            begin
                fin      = 1'b1;
                fin_cell = rd_zero_reg ? '0 : ram_rdata;
            end

            S_COPY:
            begin
                // Read row r + 1 now, write it to row r in the next cycle.
                ram_we         = pend_reg;
                ram_re         = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = cell_addr(scr_row_reg, scr_col_reg);
                if (last_col)
                begin
                    scr_col_next = '0;
                    if (CNT_W'(scr_row_reg) == h_used - CNT_W'(2))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        scr_row_next = scr_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    scr_col_next = scr_col_reg + CIDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                ram_we     = 1'b1;
                pend_next  = 1'b0;
                state_next = S_FILL;
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(ROW_W'(h_used - CNT_W'(1)), scr_col_reg);
                ram_wdata = colour_reg;
                if (last_col)
                begin
                    scr_col_next = '0;
                    state_next   = S_PUT;
                end
                else
                begin
                    scr_col_next = scr_col_reg + CIDX_W'(1);
                end
            end

            S_PUT:
            begin
                ram_we    = put_we_reg;
                ram_waddr = put_addr_reg;
                ram_wdata = put_data_reg;
                fin       = 1'b1;
                fin_scr   = 1'b1;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    cell_value_next = hold_cell_reg;
                    cursor_col_next = tcw_pkg::CURSOR_COL_W'(cur_col_reg);
                    cursor_row_next = tcw_pkg::CURSOR_ROW_W'(cur_row_reg);
                    scrolled_next   = hold_scr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished command goes to the output register, or waits in S_DONE if that register is still full.
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                cell_value_next = fin_cell;
                cursor_col_next = tcw_pkg::CURSOR_COL_W'(cur_col_next);
                cursor_row_next = tcw_pkg::CURSOR_ROW_W'(cur_row_next);
                scrolled_next   = fin_scr;
                state_next      = S_IDLE;
            end
            else
            begin
                hold_cell_next = fin_cell;
                hold_scr_next  = fin_scr;
                state_next     = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            width_reg      <= tcw_pkg::WIDTH_RESET;
            height_reg     <= tcw_pkg::HEIGHT_RESET;
            colour_reg     <= tcw_pkg::COLOUR_RESET;
            scr_row_reg    <= '0;
            scr_col_reg    <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            put_addr_reg   <= '0;
            put_data_reg   <= '0;
            put_we_reg     <= 1'b0;
            rd_zero_reg    <= 1'b0;
            hold_cell_reg  <= '0;
            hold_scr_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cell_value_reg <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            colour_reg     <= colour_next;
            scr_row_reg    <= scr_row_next;
            scr_col_reg    <= scr_col_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            put_addr_reg   <= put_addr_next;
            put_data_reg   <= put_data_next;
            put_we_reg     <= put_we_next;
            rd_zero_reg    <= rd_zero_next;
            hold_cell_reg  <= hold_cell_next;
            hold_scr_reg   <= hold_scr_next;
            out_valid_reg  <= out_valid_next;
            cell_value_reg <= cell_value_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            scrolled_reg   <= scrolled_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign scrolled   = scrolled_reg;

    // The scroll copy never reads and writes the same cell in one cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("screen RAM read and write hit the same cell");

    // No result can appear while the store is still being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result presented during the clearing pass");

    // A scrolling put reports no cell value.
    a_scroll_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && scrolled_reg) |-> (cell_value_reg == '0))
        else $error("scrolling put reported a cell value");

endmodule
